@@ sv/psvs_pkg.sv @@
// ----------------------------------------------------------------------------
// psvs_pkg
// Shared types, codes, constants and helper functions of the polyphonic sine
// voice synthesizer.
// ----------------------------------------------------------------------------
package psvs_pkg;

  // Input opcodes as carried on tuser
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ON   = 2'd1;
  localparam logic [1:0] OP_OFF  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_PHASE_SCALE = 1'b0;
  localparam logic CFG_RAMP_RECIP  = 1'b1;

  localparam logic [35:0] PHASE_SCALE_RST = 36'd5864062015;
  localparam logic [23:0] RAMP_RECIP_RST  = 24'd34953;

  // Polynomial sine coefficients, Q30
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026998;

  // 0.2 as 13107/65536
  localparam logic [13:0] MIX_COEF = 14'd13107;

  // x / 127 as (x * TGT_RECIP) >> TGT_SHIFT, exact for x < 2^30
  localparam logic [30:0] TGT_RECIP = 31'd1082196485;
  localparam int unsigned TGT_SHIFT = 37;

  localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SAMPLE_MIN = -24'sh800000;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_ON,
    KIND_OFF
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] note;
    logic [6:0] vel;
  } cmd_t;

  typedef struct packed {
    logic [6:0]         note;
    logic [23:0]        target;
    logic [31:0]        phase;
    logic [31:0]        pstep;
    logic signed [24:0] gain;
    logic signed [25:0] gstep;
  } rec_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TK_RD,
    ST_TK_X2,
    ST_TK_P5,
    ST_TK_P3,
    ST_TK_P1,
    ST_TK_S,
    ST_TK_SG,
    ST_TK_MIX,
    ST_TK_OUT,
    ST_ON_SCAN,
    ST_ON_FRQ,
    ST_ON_RMP,
    ST_ON_WR,
    ST_OF_RD,
    ST_OF_CHK,
    ST_OF_WR
  } state_e;

  // Top octave (notes 120..131) in Hz, Q16
  function automatic logic [29:0] octave_base(input logic [3:0] r);
    logic [29:0] b;
    unique case (r)
      4'd0:    b = 30'd548668578;
      4'd1:    b = 30'd581294109;
      4'd2:    b = 30'd615859655;
      4'd3:    b = 30'd652480572;
      4'd4:    b = 30'd691279090;
      4'd5:    b = 30'd732384689;
      4'd6:    b = 30'd775934544;
      4'd7:    b = 30'd822074013;
      4'd8:    b = 30'd870957082;
      4'd9:    b = 30'd922746880;
      4'd10:   b = 30'd977616269;
      4'd11:   b = 30'd1035748353;
      default: b = 30'd0;
    endcase
    return b;
  endfunction

  function automatic logic [29:0] note_freq(input logic [6:0] n);
    logic [13:0] prod;
    logic [3:0]  oct;
    logic [6:0]  rem_n;
    logic [3:0]  sh;
    logic [29:0] base;
    logic [30:0] rnd;
    // n / 12 as (n * 43) >> 9, exact over 0..127
    prod  = 14'(n) * 14'd43;
    oct   = prod[12:9];
    rem_n = n - 7'(7'(oct) * 7'd12);
    base  = octave_base(rem_n[3:0]);
    sh    = 4'd10 - oct;
    rnd   = {1'b0, base};
    if (sh != 4'd0) begin
      rnd = (rnd + (31'd1 << (sh - 4'd1))) >> sh;
    end
    return rnd[29:0];
  endfunction

  // Envelope step magnitude, never zero
  function automatic logic [23:0] ramp_step(input logic [23:0] level,
                                            input logic [23:0] recip);
    logic [47:0] p;
    logic [23:0] m;
    p = 48'(level) * 48'(recip);
    m = 24'((p + 48'd8388608) >> 24);
    if (m == 24'd0) begin
      m = 24'd1;
    end
    return m;
  endfunction

endpackage

@@ sv/psvs_front.sv @@
// ----------------------------------------------------------------------------
// psvs_front
// Accepts requests, sorts them into tick, note-on and note-off commands and
// queues them for the voice engine; unknown opcodes are dropped.
// ----------------------------------------------------------------------------
module psvs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [15:0]       s_axis_tdata_i,
  input  logic [1:0]        s_axis_tuser_i,
  output logic              cmd_valid_o,
  output psvs_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);

  psvs_pkg::cmd_t fifo_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           accept, push;
  psvs_pkg::cmd_t cmd_in;

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    cmd_in.note = s_axis_tdata_i[6:0];
    cmd_in.vel  = s_axis_tdata_i[13:7];
    cmd_in.kind = psvs_pkg::KIND_TICK;
    push        = accept;
    unique case (s_axis_tuser_i)
      psvs_pkg::OP_TICK: cmd_in.kind = psvs_pkg::KIND_TICK;
      psvs_pkg::OP_ON: begin
        // velocity zero turns a note-on into a note-off
        cmd_in.kind = (cmd_in.vel == 7'd0) ? psvs_pkg::KIND_OFF : psvs_pkg::KIND_ON;
      end
      psvs_pkg::OP_OFF: cmd_in.kind = psvs_pkg::KIND_OFF;
      default: push = 1'b0;
    endcase
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule

@@ sv/psvs_engine.sv @@
// ----------------------------------------------------------------------------
// psvs_engine
// Voice engine: walks the voice store one voice at a time to mix a sample,
// to place a new note, or to release matching notes.
// ----------------------------------------------------------------------------
module psvs_engine #(
  parameter int unsigned VOICE_COUNT     = 16,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  psvs_pkg::cmd_t       cmd_i,
  output logic                 cmd_pop_o,
  input  logic [35:0]          phase_scale_i,
  input  logic [23:0]          ramp_recip_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [23:0]   out_sample_o
);

  localparam int unsigned VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned ACC_W = 21 + VW;
  localparam logic [VW-1:0] LAST_V = VW'(VOICE_COUNT - 1);
  localparam logic [31:0] PH_MASK = ~((32'd1 << (32 - SINE_TABLE_BITS)) - 32'd1);

  psvs_pkg::state_e state_q, state_d;

  psvs_pkg::rec_t mem_q [VOICE_COUNT];
  psvs_pkg::rec_t rd_q;
  psvs_pkg::rec_t wr_rec;
  logic           mem_we;

  logic [VOICE_COUNT-1:0] active_q, rel_q;
  logic [VW-1:0]          idx_q;
  psvs_pkg::cmd_t         cmd_q;

  logic [30:0]             x_q, x2_q, t_q;
  logic                    neg_q;
  logic [23:0]             s_q;
  logic [47:0]             sg_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [31:0]             pstep_q;
  logic [23:0]             tgt_q;
  logic [23:0]             gmag_q;

  logic                    out_valid_q;
  logic signed [23:0]      out_q;

  // combinational datapath terms
  logic [31:0]             ph;
  logic [30:0]             x_d;
  logic [61:0]             prod_x;
  logic [60:0]             mix_p;
  logic [19:0]             mix_m;
  logic signed [26:0]      gsum, tgt_s;
  logic                    retire, reach;
  logic [23:0]             g_mag;
  logic [29:0]             freq;
  logic [61:0]             f_lo;
  logic [33:0]             f_hi;
  logic [60:0]             tgt_p;
  logic                    is_last, out_free;
  logic signed [ACC_W-1:0] acc_sat_hi, acc_sat_lo;

  assign is_last  = (idx_q == LAST_V);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ph     = rd_q.phase & PH_MASK;
    x_d    = ph[30] ? (31'd1 << 30) - {1'b0, ph[29:0]} : {1'b0, ph[29:0]};
    prod_x = 62'(x_q) * 62'(t_q);
    mix_p  = 61'(sg_q) * 61'(psvs_pkg::MIX_COEF);
    mix_m  = 20'((mix_p + (61'd1 << 40)) >> 41);
    gsum   = 27'(rd_q.gain) + 27'(rd_q.gstep);
    tgt_s  = $signed({3'b000, rd_q.target});
    retire = rel_q[idx_q] && (gsum <= 27'sd0);
    reach  = !rel_q[idx_q] && (gsum >= tgt_s);
    g_mag  = rd_q.gain[24] ? 24'd0 : rd_q.gain[23:0];
    freq   = psvs_pkg::note_freq(cmd_q.note);
    f_lo   = 62'(freq) * 62'(phase_scale_i[31:0]);
    f_hi   = 34'(freq) * 34'(phase_scale_i[35:32]);
    tgt_p  = 61'({cmd_q.vel, 23'd0} + 30'd63) * 61'(psvs_pkg::TGT_RECIP);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      psvs_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            psvs_pkg::KIND_TICK: state_d = psvs_pkg::ST_TK_RD;
            psvs_pkg::KIND_ON:   state_d = psvs_pkg::ST_ON_SCAN;
            psvs_pkg::KIND_OFF:  state_d = psvs_pkg::ST_OF_RD;
            default:             state_d = psvs_pkg::ST_IDLE;
          endcase
        end
      end
      psvs_pkg::ST_TK_RD: begin
        if (active_q[idx_q]) begin
          state_d = psvs_pkg::ST_TK_X2;
        end else if (is_last) begin
          state_d = psvs_pkg::ST_TK_OUT;
        end
      end
      psvs_pkg::ST_TK_X2:  state_d = psvs_pkg::ST_TK_P5;
      psvs_pkg::ST_TK_P5:  state_d = psvs_pkg::ST_TK_P3;
      psvs_pkg::ST_TK_P3:  state_d = psvs_pkg::ST_TK_P1;
      psvs_pkg::ST_TK_P1:  state_d = psvs_pkg::ST_TK_S;
      psvs_pkg::ST_TK_S:   state_d = psvs_pkg::ST_TK_SG;
      psvs_pkg::ST_TK_SG:  state_d = psvs_pkg::ST_TK_MIX;
      psvs_pkg::ST_TK_MIX: state_d = is_last ? psvs_pkg::ST_TK_OUT : psvs_pkg::ST_TK_RD;
      psvs_pkg::ST_TK_OUT: if (out_free) state_d = psvs_pkg::ST_IDLE;
      psvs_pkg::ST_ON_SCAN: begin
        if (!active_q[idx_q] || is_last) begin
          state_d = psvs_pkg::ST_ON_FRQ;
        end
      end
      psvs_pkg::ST_ON_FRQ: state_d = psvs_pkg::ST_ON_RMP;
      psvs_pkg::ST_ON_RMP: state_d = psvs_pkg::ST_ON_WR;
      psvs_pkg::ST_ON_WR:  state_d = psvs_pkg::ST_IDLE;
      psvs_pkg::ST_OF_RD: begin
        if (active_q[idx_q]) begin
          state_d = psvs_pkg::ST_OF_CHK;
        end else if (is_last) begin
          state_d = psvs_pkg::ST_IDLE;
        end
      end
      psvs_pkg::ST_OF_CHK: begin
        if (rd_q.note == cmd_q.note) begin
          state_d = psvs_pkg::ST_OF_WR;
        end else begin
          state_d = is_last ? psvs_pkg::ST_IDLE : psvs_pkg::ST_OF_RD;
        end
      end
      psvs_pkg::ST_OF_WR:  state_d = is_last ? psvs_pkg::ST_IDLE : psvs_pkg::ST_OF_RD;
      default:             state_d = psvs_pkg::ST_IDLE;
    endcase
  end

  // outputs: queue pop and voice store write
  always_comb begin
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    wr_rec    = rd_q;
    unique case (state_q)
      psvs_pkg::ST_IDLE: cmd_pop_o = cmd_valid_i;
      psvs_pkg::ST_TK_MIX: begin
        mem_we       = 1'b1;
        wr_rec.phase = rd_q.phase + rd_q.pstep;
        if (retire) begin
          wr_rec.gain = 25'sd0;
        end else if (reach) begin
          wr_rec.gain  = $signed({1'b0, rd_q.target});
          wr_rec.gstep = 26'sd0;
        end else begin
          wr_rec.gain = 25'(gsum);
        end
      end
      psvs_pkg::ST_ON_WR: begin
        mem_we        = 1'b1;
        wr_rec.note   = cmd_q.note;
        wr_rec.target = tgt_q;
        wr_rec.phase  = 32'd0;
        wr_rec.pstep  = pstep_q;
        wr_rec.gain   = 25'sd0;
        wr_rec.gstep  = $signed({2'b00, gmag_q});
      end
      psvs_pkg::ST_OF_WR: begin
        mem_we       = 1'b1;
        wr_rec.gstep = -$signed({2'b00, gmag_q});
      end
      default: ;
    endcase
  end

  // voice store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= wr_rec;
    end
    rd_q <= mem_q[idx_q];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      psvs_pkg::ST_IDLE: begin
        cmd_q <= cmd_i;
        acc_q <= '0;
      end
      psvs_pkg::ST_TK_X2: begin
        x_q   <= x_d;
        neg_q <= ph[31];
        x2_q  <= 31'((62'(x_d) * 62'(x_d)) >> 30);
      end
      psvs_pkg::ST_TK_P5: t_q <= psvs_pkg::SIN_C5 - 31'((62'(x2_q) * 62'(psvs_pkg::SIN_C7)) >> 30);
      psvs_pkg::ST_TK_P3: t_q <= psvs_pkg::SIN_C3 - 31'((62'(x2_q) * 62'(t_q)) >> 30);
      psvs_pkg::ST_TK_P1: t_q <= psvs_pkg::SIN_C1 - 31'((62'(x2_q) * 62'(t_q)) >> 30);
      psvs_pkg::ST_TK_S:  s_q <= 24'(((prod_x >> 30) + 62'd64) >> 7);
      psvs_pkg::ST_TK_SG: sg_q <= 48'(s_q) * 48'(g_mag);
      psvs_pkg::ST_TK_MIX: begin
        if (neg_q) begin
          acc_q <= acc_q - ACC_W'($signed({1'b0, mix_m}));
        end else begin
          acc_q <= acc_q + ACC_W'($signed({1'b0, mix_m}));
        end
      end
      psvs_pkg::ST_ON_FRQ: begin
        pstep_q <= 32'(f_lo >> 32) + 32'(f_hi);
        tgt_q   <= 24'(tgt_p >> psvs_pkg::TGT_SHIFT);
      end
      psvs_pkg::ST_ON_RMP: gmag_q <= psvs_pkg::ramp_step(tgt_q, ramp_recip_i);
      psvs_pkg::ST_OF_CHK: gmag_q <= psvs_pkg::ramp_step(g_mag, ramp_recip_i);
      default: ;
    endcase
  end

  assign acc_sat_hi = ACC_W'(psvs_pkg::SAMPLE_MAX);
  assign acc_sat_lo = ACC_W'(psvs_pkg::SAMPLE_MIN);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psvs_pkg::ST_IDLE;
      active_q    <= '0;
      rel_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == psvs_pkg::ST_TK_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        psvs_pkg::ST_IDLE: idx_q <= '0;
        psvs_pkg::ST_TK_RD: begin
          if (!active_q[idx_q] && !is_last) begin
            idx_q <= idx_q + VW'(1);
          end
        end
        psvs_pkg::ST_TK_MIX: begin
          if (retire) begin
            active_q[idx_q] <= 1'b0;
            rel_q[idx_q]    <= 1'b0;
          end
          if (!is_last) begin
            idx_q <= idx_q + VW'(1);
          end
        end
        psvs_pkg::ST_TK_OUT: begin
          if (out_free) begin
            if (acc_q > acc_sat_hi) begin
              out_q <= psvs_pkg::SAMPLE_MAX;
            end else if (acc_q < acc_sat_lo) begin
              out_q <= psvs_pkg::SAMPLE_MIN;
            end else begin
              out_q <= 24'(acc_q);
            end
          end
        end
        psvs_pkg::ST_ON_SCAN: begin
          // steal voice 0 when every voice is busy
          if (active_q[idx_q] && is_last) begin
            idx_q <= '0;
          end else if (active_q[idx_q]) begin
            idx_q <= idx_q + VW'(1);
          end
        end
        psvs_pkg::ST_ON_WR: begin
          active_q[idx_q] <= 1'b1;
          rel_q[idx_q]    <= 1'b0;
        end
        psvs_pkg::ST_OF_RD: begin
          if (!active_q[idx_q] && !is_last) begin
            idx_q <= idx_q + VW'(1);
          end
        end
        psvs_pkg::ST_OF_CHK: begin
          if (rd_q.note != cmd_q.note && !is_last) begin
            idx_q <= idx_q + VW'(1);
          end
        end
        psvs_pkg::ST_OF_WR: begin
          rel_q[idx_q] <= 1'b1;
          if (!is_last) begin
            idx_q <= idx_q + VW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

  a_rel_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rel_q & ~active_q) == '0)
    else $error("releasing voice is not active");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == psvs_pkg::ST_IDLE))
    else $error("command taken while busy");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == psvs_pkg::ST_TK_MIX || state_q == psvs_pkg::ST_ON_WR ||
                state_q == psvs_pkg::ST_OF_WR))
    else $error("voice store written outside an update step");

  a_on_sets_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psvs_pkg::ST_ON_WR) |=> active_q[$past(idx_q)])
    else $error("new note left its voice idle");

endmodule

@@ sv/poly_sine_voice_synth.sv @@
// ----------------------------------------------------------------------------
// poly_sine_voice_synth
// Polyphonic sine synthesizer with linear attack and release envelopes.
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        tdata: note, velocity; tuser: opcode
//  m_axis    out        tvalid / tready        tdata: sample
//  cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A tick walks the voices one at a time through one shared sine/mix
// datapath. A note-on scans for a free voice; a note-off checks each
// voice in turn for the note.
// A two-entry command queue decouples intake from the voice engine; the
// result register holds a sample until taken, stalling the next tick.
// Reset marks all voices inactive at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module poly_sine_voice_synth #(
  parameter int unsigned VOICE_COUNT     = 16,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // note[6:0], velocity[13:7]
  input  logic [1:0]  s_axis_tuser_i,   // opcode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // sample[23:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [35:0] cfg_data_i
);

  logic [35:0]        scale_q;
  logic [23:0]        ramp_q;
  logic               cmd_valid, cmd_pop;
  psvs_pkg::cmd_t     cmd;
  logic signed [23:0] sample;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= psvs_pkg::PHASE_SCALE_RST;
      ramp_q  <= psvs_pkg::RAMP_RECIP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        psvs_pkg::CFG_PHASE_SCALE: scale_q <= cfg_data_i;
        psvs_pkg::CFG_RAMP_RECIP:  ramp_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  psvs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  psvs_engine #(
    .VOICE_COUNT     (VOICE_COUNT),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .phase_scale_i (scale_q),
    .ramp_recip_i  (ramp_q),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_sample_o  (sample)
  );

  assign m_axis_tdata_o = sample;

endmodule
